@@ rtl/core/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Sizes, operation and status codes, and the control word that drives the
// row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // Storage size and word width
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Port widths fixed by the item format
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command to every cell of the row
  typedef struct packed {
    logic shift_r;   // insert at physical start, data moves up one cell
    logic shift_l;   // drop physical start, data moves down one cell
    logic wr_tail;   // write the cell just past the last entry
    logic mark_inc;  // last-entry mark moves up one cell
    logic mark_dec;  // last-entry mark moves down one cell
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/dq_cell.sv @@
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one word and a flag that marks the physical last entry. Takes its
// next word from a neighbor on a shift, or the pushed word on a tail write,
// and its next flag from a neighbor when the mark moves.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dq_pkg::cell_ctl_t            ctl,
  input  wire logic [dq_pkg::DATA_WIDTH-1:0] push_data,
  input  wire logic [dq_pkg::DATA_WIDTH-1:0] left_data,
  input  wire logic [dq_pkg::DATA_WIDTH-1:0] right_data,
  input  wire logic                         left_mark,
  input  wire logic                         right_mark,
  output logic      [dq_pkg::DATA_WIDTH-1:0] data,
  output logic                              mark
);

  // Move the last-entry mark with the count
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (ctl.mark_inc) begin
      mark <= left_mark;
    end else if (ctl.mark_dec) begin
      mark <= right_mark;
    end
  end

  // Shift the word along the row, or take the pushed word past the tail
  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      data <= left_data;
    end else if (ctl.shift_l) begin
      data <= right_data;
    end else if (ctl.wr_tail && left_mark) begin
      data <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl: operation decode, count, order flag and result register
// Turns each accepted item into a command for the cell row, then loads the
// result from the updated row into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [dq_pkg::OP_W-1:0]       op,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  input  wire logic [dq_pkg::DATA_WIDTH-1:0] first_data,
  input  wire logic [dq_pkg::DATA_WIDTH-1:0] last_data,
  output dq_pkg::cell_ctl_t                  ctl,
  output logic                               empty,
  output logic      [dq_pkg::VALUE_W-1:0]    front_value,
  output logic      [dq_pkg::VALUE_W-1:0]    back_value,
  output logic      [dq_pkg::COUNT_W-1:0]    item_count,
  output logic                               is_empty,
  output logic                               is_full,
  output logic      [dq_pkg::STATUS_W-1:0]   status
);

  logic [dq_pkg::CNT_W-1:0] count;
  logic [dq_pkg::CNT_W-1:0] count_next;
  logic                     reversed;
  logic                     reversed_next;
  logic                     pend;
  dq_pkg::status_t          pend_status;
  dq_pkg::status_t          status_next;
  logic                     accept;
  logic                     full;
  logic                     load;
  logic [dq_pkg::DATA_WIDTH-1:0] phys_first;
  logic [dq_pkg::DATA_WIDTH-1:0] phys_last;

  assign item_stall = pend;
  assign accept     = item_valid && !pend;
  assign empty      = (count == '0);
  assign full       = (count == dq_pkg::CNT_W'(dq_pkg::CAPACITY));
  assign load       = pend && (!result_valid || !result_stall);

  // Decode the operation into a row command, count and order updates
  always_comb begin
    ctl           = '0;
    count_next    = count;
    reversed_next = reversed;
    status_next   = dq_pkg::ST_OK;
    if (accept) begin
      unique case (dq_pkg::op_t'(op))
        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_next = dq_pkg::ST_FULL;
          end else begin
            ctl.mark_inc = 1'b1;
            count_next   = count + 1'b1;
            if ((op == dq_pkg::OP_PUSH_FRONT) != reversed) begin
              ctl.shift_r = 1'b1;
            end else begin
              ctl.wr_tail = 1'b1;
            end
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_next = dq_pkg::ST_EMPTY;
          end else begin
            ctl.mark_dec = 1'b1;
            count_next   = count - 1'b1;
            if ((op == dq_pkg::OP_POP_FRONT) != reversed) begin
              ctl.shift_l = 1'b1;
            end
          end
        end
        dq_pkg::OP_REVERSE: begin
          if (empty) begin
            status_next = dq_pkg::ST_EMPTY;
          end else begin
            reversed_next = !reversed;
          end
        end
        default: begin
          status_next = dq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Hold queue state and the pending status
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      reversed    <= 1'b0;
      pend        <= 1'b0;
      pend_status <= dq_pkg::ST_OK;
    end else begin
      count    <= count_next;
      reversed <= reversed_next;
      if (accept) begin
        pend        <= 1'b1;
        pend_status <= status_next;
      end else if (load) begin
        pend <= 1'b0;
      end
    end
  end

  // Zero the end words of an empty queue
  assign phys_first = empty ? '0 : first_data;
  assign phys_last  = empty ? '0 : last_data;

  // Load the result register from the updated row, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_value <= dq_pkg::VALUE_W'(reversed ? phys_last : phys_first);
      back_value  <= dq_pkg::VALUE_W'(reversed ? phys_first : phys_last);
      item_count  <= dq_pkg::COUNT_W'(count);
      is_empty    <= empty;
      is_full     <= full;
      status      <= pend_status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/double_ended_queue_with_reverse.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse: bounded deque with one-step reversal
// Entries sit in a row of cells, physical first entry in cell 0. A
// reversed flag swaps which physical end is the logical front.
//
//   channel | handshake                 | payload
//   item    | item_valid / item_stall   | op, value
//   result  | result_valid / result_stall | front_value, back_value,
//           |                           | item_count, is_empty, is_full, status
//
// Order: the row updates at the accept edge; the result register then loads
// from the updated row, and no new item is accepted until it has loaded.
// Reset: count, order flag, marks and handshake clear; cell words are not
// cleared and are never shown before being written.
// Stalls: item_stall is high while an item waits for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_with_reverse (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [dq_pkg::OP_W-1:0]       op,
  input  wire logic [dq_pkg::VALUE_W-1:0]    value,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic      [dq_pkg::VALUE_W-1:0]    front_value,
  output logic      [dq_pkg::VALUE_W-1:0]    back_value,
  output logic      [dq_pkg::COUNT_W-1:0]    item_count,
  output logic                               is_empty,
  output logic                               is_full,
  output logic      [dq_pkg::STATUS_W-1:0]   status
);

  localparam int N = dq_pkg::CAPACITY;
  localparam int W = dq_pkg::DATA_WIDTH;

  dq_pkg::cell_ctl_t ctl;
  logic              empty;
  logic [W-1:0]      push_data;
  logic [W-1:0]      cell_data [N];
  logic [N-1:0]      last_mark;
  logic [W-1:0]      last_data;

  assign push_data = value[W-1:0];

  // Row of storage cells, each linked to its two neighbors
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] left_d;
    logic [W-1:0] right_d;
    logic         left_m;
    logic         right_m;

    if (i == 0) begin : g_first
      assign left_d = push_data;
      assign left_m = empty;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign left_m = last_mark[i-1];
    end

    if (i == N - 1) begin : g_end
      assign right_d = '0;
      assign right_m = 1'b0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
      assign right_m = last_mark[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .push_data  (push_data),
      .left_data  (left_d),
      .right_data (right_d),
      .left_mark  (left_m),
      .right_mark (right_m),
      .data       (cell_data[i]),
      .mark       (last_mark[i])
    );
  end

  // Pick the word under the last-entry mark
  always_comb begin
    last_data = '0;
    for (int i = 0; i < N; i++) begin
      last_data = last_data | (cell_data[i] & {W{last_mark[i]}});
    end
  end

  dq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .first_data   (cell_data[0]),
    .last_data    (last_data),
    .ctl          (ctl),
    .empty        (empty),
    .front_value  (front_value),
    .back_value   (back_value),
    .item_count   (item_count),
    .is_empty     (is_empty),
    .is_full      (is_full),
    .status       (status)
  );

  // At most one cell carries the last-entry mark
  a_mark_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(last_mark))
    else $error("more than one last-entry mark");

  // An accepted item blocks the next one until its result is loaded
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while previous one pending");

  // A full push reports a full queue
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == dq_pkg::ST_FULL) |-> (is_full && !is_empty))
    else $error("push-on-full status without full queue");

  // An empty pop or reverse reports an empty queue with zero ends
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == dq_pkg::ST_EMPTY)
      |-> (is_empty && front_value == '0 && back_value == '0))
    else $error("empty status without empty queue");

endmodule

`default_nettype wire
